// File: hdl/ray_triangle_intersect_assert.svh
// assertion helpers shared by the intersect block
`ifndef RAY_TRIANGLE_INTERSECT_ASSERT_SVH
`define RAY_TRIANGLE_INTERSECT_ASSERT_SVH

// implication checked on every clock edge outside reset
`define RTI_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// condition that must never hold outside reset
`define RTI_ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// File: hdl/rti_pkg.sv
package rti_pkg;

   // coordinates are fixed 16-bit signed fixed point
   localparam int CoordW = 16;
   // width of determinant and numerators
   localparam int WW = 53;
   // width of the distance threshold compare
   localparam int TW = 70;
   // low slice width for splitting epsilon times det
   localparam int SplitW = 27;
   // quotient bits: 16 integer and 16 fraction
   localparam int QW = 32;
   localparam int QDepth = 2;
   localparam int QAw = $clog2(QDepth);

   typedef logic signed [CoordW-1:0] coord_type;

   // configuration register indexes
   typedef enum logic [1:0] {
      REG_VERTEX = 2'd0,
      REG_EDGE_P = 2'd1,
      REG_EDGE_Q = 2'd2,
      REG_EPSILON = 2'd3
   } reg_index_type;

   typedef struct packed {
      coord_type ox;
      coord_type oy;
      coord_type oz;
      coord_type dx;
      coord_type dy;
      coord_type dz;
   } ray_type;

   typedef struct packed {
      logic [3*CoordW-1:0] vertex;
      logic [3*CoordW-1:0] edge_p;
      logic [3*CoordW-1:0] edge_q;
      logic [CoordW-1:0]   eps;
   } tri_cfg_type;

   // one classified item waiting for its division
   typedef struct packed {
      logic          hit;
      logic          sat;
      logic [WW-1:0] tn;
      logic [WW-1:0] adet;
   } qent_type;

   typedef struct packed {
      logic     valid;
      qent_type ent;
   } push_type;

   // pick coordinate k (0 = x) out of a packed triple
   function automatic coord_type coord_of(logic [3*CoordW-1:0] p, int k);
      coord_of = p[CoordW*k +: CoordW];
   endfunction

endpackage

// File: hdl/rti_front.sv
module rti_front import rti_pkg::*; #(
   parameter int FRAC_BITS = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   input  ray_type     ray,
   input  tri_cfg_type cfg,
   output push_type    push
);

   logic [7:1] v_ff;

   logic signed [15:0] dir1_ff[3];
   logic signed [16:0] tv1_ff[3];
   logic signed [16:0] tv_in[3];
   coord_type org[3];
   coord_type dir[3];
   coord_type vtx[3];
   coord_type ep[3];
   coord_type eq[3];

   logic signed [31:0] ea2_ff[3];
   logic signed [31:0] eb2_ff[3];
   logic signed [32:0] wa2_ff[3];
   logic signed [32:0] wb2_ff[3];
   logic signed [15:0] dir2_ff[3];
   logic signed [16:0] tv2_ff[3];

   logic signed [32:0] e3_ff[3];
   logic signed [33:0] w3_ff[3];
   logic signed [15:0] dir3_ff[3];
   logic signed [16:0] tv3_ff[3];

   logic signed [WW-1:0] pd4_ff[3];
   logic signed [WW-1:0] pu4_ff[3];
   logic signed [WW-1:0] pv4_ff[3];
   logic signed [WW-1:0] pt4_ff[3];

   logic signed [WW-1:0] det5_ff;
   logic signed [WW-1:0] un5_ff;
   logic signed [WW-1:0] vn5_ff;
   logic signed [WW-1:0] tn5_ff;

   logic signed [WW-1:0] det_a;
   logic signed [WW-1:0] un_a;
   logic signed [WW-1:0] vn_a;
   logic signed [WW-1:0] tn_a;
   logic signed [WW:0]   uv_sum;
   logic [WW-1:0]        eps_scaled;
   logic                 miss6_in;
   logic [WW-1:0]        adet6_ff;
   logic [WW-1:0]        tn6_ff;
   logic                 miss6_ff;

   logic [CoordW+SplitW-1:0]    pplo7_ff;
   logic [CoordW+WW-SplitW-1:0] pphi7_ff;
   logic [WW-1:0]               adet7_ff;
   logic [WW-1:0]               tn7_ff;
   logic                        miss7_ff;
   logic                        sat7_ff;

   logic [TW-1:0] eps_prod;
   logic [TW-1:0] tn_scaled;

   // unpack ray and triangle
   always_comb begin
      org[0] = ray.ox;
      org[1] = ray.oy;
      org[2] = ray.oz;
      dir[0] = ray.dx;
      dir[1] = ray.dy;
      dir[2] = ray.dz;
      for (int k = 0; k < 3; k++) begin
         vtx[k] = coord_of(cfg.vertex, k);
         ep[k] = coord_of(cfg.edge_p, k);
         eq[k] = coord_of(cfg.edge_q, k);
         tv_in[k] = 17'(org[k]) - 17'(vtx[k]);
      end
   end

   // valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= {v_ff[6:1], in_valid};
      end
   end

   for (genvar g = 0; g < 3; g++) begin : g_axis
      localparam int J = (g + 1) % 3;
      localparam int K = (g + 2) % 3;

      // stage 1: origin relative to the vertex
      always_ff @(posedge clock) begin
         dir1_ff[g] <= dir[g];
         tv1_ff[g] <= tv_in[g];
      end

      // stage 2: cross product terms
      always_ff @(posedge clock) begin
         ea2_ff[g] <= dir1_ff[J] * eq[K];
         eb2_ff[g] <= dir1_ff[K] * eq[J];
         wa2_ff[g] <= tv1_ff[J] * ep[K];
         wb2_ff[g] <= tv1_ff[K] * ep[J];
         dir2_ff[g] <= dir1_ff[g];
         tv2_ff[g] <= tv1_ff[g];
      end

      // stage 3: cross products e and w
      always_ff @(posedge clock) begin
         e3_ff[g] <= 33'(ea2_ff[g]) - 33'(eb2_ff[g]);
         w3_ff[g] <= 34'(wa2_ff[g]) - 34'(wb2_ff[g]);
         dir3_ff[g] <= dir2_ff[g];
         tv3_ff[g] <= tv2_ff[g];
      end

      // stage 4: dot product terms
      always_ff @(posedge clock) begin
         pd4_ff[g] <= WW'(ep[g] * e3_ff[g]);
         pu4_ff[g] <= WW'(tv3_ff[g] * e3_ff[g]);
         pv4_ff[g] <= WW'(dir3_ff[g] * w3_ff[g]);
         pt4_ff[g] <= WW'(eq[g] * w3_ff[g]);
      end
   end

   // stage 5: determinant and numerators
   always_ff @(posedge clock) begin
      det5_ff <= pd4_ff[0] + pd4_ff[1] + pd4_ff[2];
      un5_ff <= pu4_ff[0] + pu4_ff[1] + pu4_ff[2];
      vn5_ff <= pv4_ff[0] + pv4_ff[1] + pv4_ff[2];
      tn5_ff <= pt4_ff[0] + pt4_ff[1] + pt4_ff[2];
   end

   // stage 6: fold the sign of det, range tests
   always_comb begin
      if (det5_ff[WW-1]) begin
         det_a = -det5_ff;
         un_a = -un5_ff;
         vn_a = -vn5_ff;
         tn_a = -tn5_ff;
      end else begin
         det_a = det5_ff;
         un_a = un5_ff;
         vn_a = vn5_ff;
         tn_a = tn5_ff;
      end
      uv_sum = (WW+1)'(un_a) + (WW+1)'(vn_a);
      eps_scaled = WW'(cfg.eps) << (2 * FRAC_BITS);
      miss6_in = (det_a == '0) || (WW'(det_a) < eps_scaled)
         || un_a[WW-1] || (un_a > det_a)
         || vn_a[WW-1] || (uv_sum > (WW+1)'(det_a))
         || tn_a[WW-1];
   end

   always_ff @(posedge clock) begin
      adet6_ff <= WW'(det_a);
      tn6_ff <= WW'(tn_a);
      miss6_ff <= miss6_in;
   end

   // stage 7: epsilon times det in two slices, saturation test
   always_ff @(posedge clock) begin
      pplo7_ff <= cfg.eps * adet6_ff[SplitW-1:0];
      pphi7_ff <= cfg.eps * adet6_ff[WW-1:SplitW];
      adet7_ff <= adet6_ff;
      tn7_ff <= tn6_ff;
      miss7_ff <= miss6_ff;
      sat7_ff <= {16'd0, tn6_ff} >= {adet6_ff, 16'd0};
   end

   // distance below epsilon is a miss
   always_comb begin
      eps_prod = (TW'(pphi7_ff) << SplitW) + TW'(pplo7_ff);
      tn_scaled = TW'(tn7_ff) << FRAC_BITS;
      push.valid = v_ff[7];
      push.ent.hit = !miss7_ff && !(tn_scaled < eps_prod);
      push.ent.sat = sat7_ff;
      push.ent.tn = tn7_ff;
      push.ent.adet = adet7_ff;
   end

endmodule

// File: hdl/rti_queue.sv
module rti_queue import rti_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  push_type push,
   output push_type head
);

`include "ray_triangle_intersect_assert.svh"

   qent_type       mem_ff[QDepth];
   logic [QAw-1:0] wr_ff;
   logic [QAw-1:0] rd_ff;
   logic [QAw:0]   count_ff;
   logic           pop;

   // the back part takes an item whenever one waits
   assign pop = (count_ff != '0);
   assign head.valid = pop;
   assign head.ent = mem_ff[rd_ff];

   // storage
   always_ff @(posedge clock) begin
      if (push.valid) begin
         mem_ff[wr_ff] <= push.ent;
      end
   end

   // pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         count_ff <= '0;
      end else begin
         if (push.valid) begin
            wr_ff <= wr_ff + 1'b1;
         end
         if (pop) begin
            rd_ff <= rd_ff + 1'b1;
         end
         count_ff <= count_ff + (QAw+1)'(push.valid) - (QAw+1)'(pop);
      end
   end

   `RTI_ASSERT_NEVER(a_queue_no_overflow, clock, reset, count_ff > (QAw+1)'(QDepth) - 1'b1, "queue overfilled")

endmodule

// File: hdl/rti_back.sv
module rti_back import rti_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  push_type      head,
   output logic          done,
   output logic          hit,
   output logic          sat,
   output logic [QW-1:0] quot
);

   localparam int Steps = QW;

   logic [Steps:0]  v_ff;
   logic [WW-1:0]   r_ff[Steps+1];
   logic [QW-1:0]   low_ff[Steps+1];
   logic [QW-1:0]   q_ff[Steps+1];
   logic [WW-1:0]   d_ff[Steps+1];
   logic [Steps:0]  hit_ff;
   logic [Steps:0]  sat_ff;

   // load: upper dividend bits, lower ones shift in one per step
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else begin
         v_ff[0] <= head.valid;
      end
   end

   always_ff @(posedge clock) begin
      r_ff[0] <= head.ent.tn >> 16;
      low_ff[0] <= {head.ent.tn[15:0], 16'd0};
      q_ff[0] <= '0;
      d_ff[0] <= head.ent.adet;
      hit_ff[0] <= head.ent.hit;
      sat_ff[0] <= head.ent.sat;
   end

   // one restoring division step per stage
   for (genvar s = 0; s < Steps; s++) begin : g_step
      logic [WW:0] trial;
      logic        take;

      always_comb begin
         trial = {r_ff[s], low_ff[s][QW-1]};
         take = trial >= (WW+1)'(d_ff[s]);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[s+1] <= 1'b0;
         end else begin
            v_ff[s+1] <= v_ff[s];
         end
      end

      always_ff @(posedge clock) begin
         r_ff[s+1] <= take ? WW'(trial - (WW+1)'(d_ff[s])) : WW'(trial);
         low_ff[s+1] <= low_ff[s] << 1;
         q_ff[s+1] <= {q_ff[s][QW-2:0], take};
         d_ff[s+1] <= d_ff[s];
         hit_ff[s+1] <= hit_ff[s];
         sat_ff[s+1] <= sat_ff[s];
      end
   end

   assign done = v_ff[Steps];
   assign hit = hit_ff[Steps];
   assign sat = sat_ff[Steps];
   assign quot = q_ff[Steps];

endmodule

// File: hdl/ray_triangle_intersect.sv
// channel   ports                       handshake
// request   req_origin_*, req_dir_*     start high while busy low
// response  rsp_hit, rsp_distance       rsp_strobe for one cycle
// config    csr_index, csr_wdata        csr_we, taken at once
//
// one ray accepted per cycle; busy stays low
// rsp_strobe rises once the ray has passed seven front stages (the first at the
// accepting edge), the queue, a divider load stage, 32 divider steps and the
// output register
// reset clears the triangle to zero and epsilon to one
// the receiver cannot stall; the queue between front and divider never backs up
module ray_triangle_intersect import rti_pkg::*; #(
   parameter int FRAC_BITS = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic signed [15:0] req_origin_x,
   input  logic signed [15:0] req_origin_y,
   input  logic signed [15:0] req_origin_z,
   input  logic signed [15:0] req_dir_x,
   input  logic signed [15:0] req_dir_y,
   input  logic signed [15:0] req_dir_z,
   output logic              rsp_strobe,
   output logic              rsp_hit,
   output logic [31:0]       rsp_distance,
   input  logic              csr_we,
   input  logic [1:0]        csr_index,
   input  logic [47:0]       csr_wdata
);

`include "ray_triangle_intersect_assert.svh"

   tri_cfg_type   cfg_ff;
   ray_type       ray;
   push_type      push;
   push_type      head;
   logic          done;
   logic          b_hit;
   logic          b_sat;
   logic [QW-1:0] quot;
   logic          strobe_ff;
   logic          hit_ff;
   logic [31:0]   dist_ff;
   logic [31:0]   dist_in;

   assign busy = 1'b0;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.vertex <= '0;
         cfg_ff.edge_p <= '0;
         cfg_ff.edge_q <= '0;
         cfg_ff.eps <= 16'd1;
      end else if (csr_we) begin
         case (reg_index_type'(csr_index))
            REG_VERTEX:  cfg_ff.vertex <= csr_wdata;
            REG_EDGE_P:  cfg_ff.edge_p <= csr_wdata;
            REG_EDGE_Q:  cfg_ff.edge_q <= csr_wdata;
            REG_EPSILON: cfg_ff.eps <= csr_wdata[15:0];
            default:     cfg_ff.eps <= cfg_ff.eps;
         endcase
      end
   end

   always_comb begin
      ray.ox = req_origin_x;
      ray.oy = req_origin_y;
      ray.oz = req_origin_z;
      ray.dx = req_dir_x;
      ray.dy = req_dir_y;
      ray.dz = req_dir_z;
   end

   rti_front #(
      .FRAC_BITS(FRAC_BITS)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .in_valid(start && !busy),
      .ray(ray),
      .cfg(cfg_ff),
      .push(push)
   );

   rti_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push(push),
      .head(head)
   );

   rti_back u_back (
      .clock(clock),
      .reset(reset),
      .head(head),
      .done(done),
      .hit(b_hit),
      .sat(b_sat),
      .quot(quot)
   );

   // distance: saturate, zero on a miss
   always_comb begin
      if (!b_hit) begin
         dist_in = '0;
      end else if (b_sat) begin
         dist_in = '1;
      end else begin
         dist_in = quot;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
         hit_ff <= 1'b0;
      end else begin
         strobe_ff <= done;
         hit_ff <= done && b_hit;
      end
   end

   always_ff @(posedge clock) begin
      dist_ff <= dist_in;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_hit = hit_ff;
   assign rsp_distance = dist_ff;

   `RTI_ASSERT_IMP(a_hit_only_with_strobe, clock, reset, rsp_hit, rsp_strobe, "hit without strobe")
   `RTI_ASSERT_IMP(a_miss_zero_distance, clock, reset, rsp_strobe && !rsp_hit, rsp_distance == '0, "miss with distance")

endmodule
